/* src/fcl_pkg.sv */
// fcl_pkg: shared types and constants for the cluster chain sector locator
// used by fcl_div and fat_cluster_chain_sector_locator_core
// no dependencies
package fcl_pkg;

	// serial divider sizes
	localparam int unsigned DIV_N_W   = 32;
	localparam int unsigned DIV_D_W   = 13;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);

	// input word kinds
	localparam logic OP_START = 1'b0;
	localparam logic OP_ENTRY = 1'b1;

	// result word kinds
	localparam logic [1:0] KIND_REQUEST = 2'd0;
	localparam logic [1:0] KIND_FOUND   = 2'd1;
	localparam logic [1:0] KIND_FAIL    = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_BYTES_PER_SECTOR    = 3'd0;
	localparam logic [2:0] CFG_SECTORS_PER_CLUSTER = 3'd1;
	localparam logic [2:0] CFG_FAT_START_SECTOR    = 3'd2;
	localparam logic [2:0] CFG_DATA_START_SECTOR   = 3'd3;
	localparam logic [2:0] CFG_DATA_SECTOR_COUNT   = 3'd4;
	localparam logic [2:0] CFG_TABLE_TYPE          = 3'd5;

	localparam logic [1:0] TABLE_FAT32 = 2'd2;

	// table entry checks
	localparam logic [31:0] ENTRY_MASK  = 32'h0FFF_FFFF;
	localparam logic [31:0] CLUSTER_MIN = 32'd2;
	localparam logic [31:0] CLUSTER_MAX = 32'h0FFF_FFEF;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* src/fcl_div.sv */
// fcl_div: restoring divider, one quotient bit per cycle
// depends on fcl_pkg for widths and the status struct
module fcl_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fcl_pkg::DIV_N_W-1:0]   dividend,
	input  logic [fcl_pkg::DIV_D_W-1:0]   divisor,
	output logic [fcl_pkg::DIV_N_W-1:0]   quotient,
	output logic [fcl_pkg::DIV_D_W-1:0]   remainder,
	output fcl_pkg::div_stat_t            stat
);

	logic [fcl_pkg::DIV_N_W-1:0]   quo_q;
	logic [fcl_pkg::DIV_D_W-1:0]   rem_q;
	logic [fcl_pkg::DIV_D_W-1:0]   dvs_q;
	logic [fcl_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [fcl_pkg::DIV_D_W:0]     shf;
	logic [fcl_pkg::DIV_D_W:0]     diff;
	logic                          ge;
	logic                          last;

	assign shf  = {rem_q, quo_q[fcl_pkg::DIV_N_W-1]};
	assign diff = shf - {1'b0, dvs_q};
	assign ge   = (shf >= {1'b0, dvs_q});
	assign last = (cnt_q == fcl_pkg::DIV_CNT_W'(fcl_pkg::DIV_N_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[fcl_pkg::DIV_N_W-2:0], ge};
			rem_q <= ge ? diff[fcl_pkg::DIV_D_W-1:0] : shf[fcl_pkg::DIV_D_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* src/fat_cluster_chain_sector_locator_core.sv */
// fat_cluster_chain_sector_locator_core: follows a FAT32 cluster chain and
// turns a start cluster and sector index into an absolute data sector
// depends on fcl_pkg and fcl_div
//
// channel  direction  handshake              payload
// s_       in         s_tvalid / s_tready    tuser op, tdata start, index, entry
// m_       out        m_tvalid / m_tready    tuser kind, tdata sector, offset
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a start runs the 32-step serial divider for its hop count and, when a
// table read is needed, again for the read position; an entry that leads to
// another read runs it once; the last entry of a chain and a word that fails
// on arrival skip it; a waiting result lets one more word in; the next result
// then holds the block until the first is taken
// reset clears control state and loads configuration defaults
module fat_cluster_chain_sector_locator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,    // start_cluster, sector_index, table_entry
	input  logic [0:0]  s_tuser,    // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // sector, byte_offset, zero fill
	output logic [1:0]  m_tuser,    // kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_HOPS   = 7'b0000010,
		ST_DECIDE = 7'b0000100,
		ST_MUL    = 7'b0001000,
		ST_FIN    = 7'b0010000,
		ST_POS    = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

	state_t      state_q;
	logic        busy_q;

	logic [12:0] bps_q;
	logic [7:0]  spc_q;
	logic [31:0] fat_q;
	logic [31:0] ds_q;
	logic [31:0] cnt_q;
	logic [1:0]  tt_q;

	logic [31:0] cur_q;
	logic [31:0] hops_q;
	logic [7:0]  sic_q;
	logic [39:0] prod_q;
	logic [32:0] end_q;

	logic [1:0]  res_kind_q;
	logic [31:0] res_sector_q;
	logic [11:0] res_off_q;

	logic        m_tvalid_q;
	logic [1:0]  m_kind_q;
	logic [31:0] m_sector_q;
	logic [11:0] m_off_q;

	logic        in_acc;
	logic        in_op;
	logic [31:0] in_start;
	logic [31:0] in_idx;
	logic [31:0] in_ent;
	logic        ent_ok;
	logic        idle_fail;
	logic        idle_start;
	logic        idle_entry;
	logic        dec_fail;
	logic        dec_req;
	logic        hops_zero;
	logic        hops_done;
	logic        pos_done;
	logic        m_load;
	logic [31:0] cur_m2;
	logic [39:0] prod_w;
	logic [40:0] abs_w;
	logic        fin_fail;

	logic                          div_start;
	logic [fcl_pkg::DIV_N_W-1:0]   div_dividend;
	logic [fcl_pkg::DIV_D_W-1:0]   div_divisor;
	logic [fcl_pkg::DIV_N_W-1:0]   div_quo;
	logic [fcl_pkg::DIV_D_W-1:0]   div_rem;
	fcl_pkg::div_stat_t            div_stat;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign in_op     = s_tuser[0];
	assign in_start  = s_tdata[31:0];
	assign in_idx    = s_tdata[63:32];
	assign in_ent    = s_tdata[95:64] & fcl_pkg::ENTRY_MASK;
	assign ent_ok    = (in_ent >= fcl_pkg::CLUSTER_MIN) && (in_ent <= fcl_pkg::CLUSTER_MAX);

	assign idle_start = in_acc && (in_op == fcl_pkg::OP_START) && (spc_q != 8'd0);
	assign idle_entry = in_acc && (in_op == fcl_pkg::OP_ENTRY) && busy_q && ent_ok;
	assign idle_fail  = in_acc && (((in_op == fcl_pkg::OP_START) && (spc_q == 8'd0)) ||
	                    ((in_op == fcl_pkg::OP_ENTRY) && busy_q && !ent_ok));

	assign hops_zero = (hops_q == 32'd0);
	assign dec_req   = (state_q == ST_DECIDE) && !hops_zero &&
	                   (tt_q == fcl_pkg::TABLE_FAT32) && (bps_q != 13'd0);
	assign dec_fail  = (state_q == ST_DECIDE) &&
	                   ((hops_zero && (cur_q < fcl_pkg::CLUSTER_MIN)) ||
	                   (!hops_zero && ((tt_q != fcl_pkg::TABLE_FAT32) || (bps_q == 13'd0))));
	assign hops_done = (state_q == ST_HOPS) && div_stat.done;
	assign pos_done  = (state_q == ST_POS) && div_stat.done;

	assign div_start    = idle_start || dec_req;
	assign div_dividend = (state_q == ST_DECIDE) ? {cur_q[29:0], 2'b00} : in_idx;
	assign div_divisor  = (state_q == ST_DECIDE) ? bps_q : {5'd0, spc_q};

	assign cur_m2   = cur_q - fcl_pkg::CLUSTER_MIN;
	assign prod_w   = {8'd0, cur_m2} * {32'd0, spc_q};
	assign abs_w    = {9'd0, ds_q} + {1'b0, prod_q} + {33'd0, sic_q};
	assign fin_fail = (abs_w >= {8'd0, end_q}) || (abs_w[40:32] != 9'd0);

	assign m_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	fcl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quo),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			busy_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			bps_q      <= 13'd512;
			spc_q      <= 8'd1;
			fat_q      <= '0;
			ds_q       <= '0;
			cnt_q      <= '0;
			tt_q       <= fcl_pkg::TABLE_FAT32;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					fcl_pkg::CFG_BYTES_PER_SECTOR:    bps_q <= cfg_data[12:0];
					fcl_pkg::CFG_SECTORS_PER_CLUSTER: spc_q <= cfg_data[7:0];
					fcl_pkg::CFG_FAT_START_SECTOR:    fat_q <= cfg_data;
					fcl_pkg::CFG_DATA_START_SECTOR:   ds_q  <= cfg_data;
					fcl_pkg::CFG_DATA_SECTOR_COUNT:   cnt_q <= cfg_data;
					fcl_pkg::CFG_TABLE_TYPE:          tt_q  <= cfg_data[1:0];
					default: ;
				endcase
			end

			if (m_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (idle_fail) begin
						busy_q  <= 1'b0;
						state_q <= ST_OUT;
					end else if (idle_start) begin
						state_q <= ST_HOPS;
					end else if (idle_entry) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_HOPS: begin
					if (div_stat.done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (dec_fail) begin
						busy_q  <= 1'b0;
						state_q <= ST_OUT;
					end else if (hops_zero) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_POS;
					end
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					busy_q  <= 1'b0;
					state_q <= ST_OUT;
				end
				ST_POS: begin
					if (div_stat.done) begin
						busy_q  <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (idle_start) begin
			cur_q <= in_start;
		end
		if (idle_entry) begin
			cur_q  <= in_ent;
			hops_q <= hops_q - 32'd1;
		end
		if (hops_done) begin
			hops_q <= div_quo;
			sic_q  <= div_rem[7:0];
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_w;
			end_q  <= {1'b0, ds_q} + {1'b0, cnt_q};
		end

		if (idle_fail || dec_fail) begin
			res_kind_q   <= fcl_pkg::KIND_FAIL;
			res_sector_q <= '0;
			res_off_q    <= '0;
		end else if (state_q == ST_FIN) begin
			res_kind_q   <= fin_fail ? fcl_pkg::KIND_FAIL : fcl_pkg::KIND_FOUND;
			res_sector_q <= fin_fail ? 32'd0 : abs_w[31:0];
			res_off_q    <= '0;
		end else if (pos_done) begin
			res_kind_q   <= fcl_pkg::KIND_REQUEST;
			res_sector_q <= fat_q + div_quo;
			res_off_q    <= div_rem[11:0];
		end

		if (m_load) begin
			m_kind_q   <= res_kind_q;
			m_sector_q <= res_sector_q;
			m_off_q    <= res_off_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_kind_q;
	assign m_tdata  = {4'd0, m_off_q, m_sector_q};

`ifndef SYNTHESIS
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_HOPS || state_q == ST_POS))
		else $error("divider running outside a division state");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pos_done |=> busy_q)
		else $error("table request issued without chain in progress");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == fcl_pkg::KIND_FAIL) |-> (m_tdata == 48'd0))
		else $error("failure word carries data");

	a_found_off: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == fcl_pkg::KIND_FOUND) |-> (m_tdata[43:32] == 12'd0))
		else $error("found word carries a byte offset");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == fcl_pkg::KIND_REQUEST || m_tuser == fcl_pkg::KIND_FOUND ||
		m_tuser == fcl_pkg::KIND_FAIL))
		else $error("result word with unknown kind");
`endif

endmodule
